### design/tpcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcb_pkg
// Shared types, constants and helpers of the palette expander with color
// bleed into transparent pixels.
// ----------------------------------------------------------------------------
package tpcb_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int PALETTE_SIZE = 256;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int PAL_AW       = $clog2(PALETTE_SIZE);
	localparam int RGB_W        = 24;
	localparam int ENTRY_W      = RGB_W + 1;
	localparam int WIDTH_W      = 11;
	localparam int HEIGHT_W     = 13;
	localparam int SUM_W        = 11;
	localparam int CNT_W        = 4;
	localparam int RECIP_W      = 17;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

	localparam logic [1:0] MODE_PALETTE = 2'd0;
	localparam logic [1:0] MODE_PIXEL   = 2'd1;
	localparam logic [1:0] MODE_DRAIN   = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SUM1,
		ST_OUT1,
		ST_SUM2,
		ST_OUT2
	} state_t;

	// neighborhood request for one emitted pixel
	typedef struct packed {
		logic cc_right;  // center in the newest column
		logic left_ok;
		logic right_ok;
		logic up_ok;
		logic down_ok;
	} blend_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// ceil(2^16 / n); floor(s / n) == (s * recip) >> 16 for s < 2048
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		begin
			unique case (n)
				4'd1: r = 17'd65536;
				4'd2: r = 17'd32768;
				4'd3: r = 17'd21846;
				4'd4: r = 17'd16384;
				4'd5: r = 17'd13108;
				4'd6: r = 17'd10923;
				4'd7: r = 17'd9363;
				4'd8: r = 17'd8192;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

### design/tpcb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcb_if
// Request channels: input items and emitted BGRA pixels.
// ----------------------------------------------------------------------------
interface tpcb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] palette_slot;
	logic [7:0] entry_red;
	logic [7:0] entry_green;
	logic [7:0] entry_blue;
	logic [7:0] pixel_index;

	modport source (output valid, mode, palette_slot, entry_red, entry_green,
		entry_blue, pixel_index, input ready);
	modport sink (input valid, mode, palette_slot, entry_red, entry_green,
		entry_blue, pixel_index, output ready);
endinterface

interface tpcb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_alpha;
	logic       frame_last;

	modport source (output valid, out_blue, out_green, out_red, out_alpha,
		frame_last, input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_alpha,
		frame_last, output ready);
endinterface

### design/tpcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcb_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tpcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end
endmodule

### design/tpcb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcb_blend
// Neighbor sum stage (registered) followed by reciprocal divide.
// ----------------------------------------------------------------------------
module tpcb_blend import tpcb_pkg::*; (
	input  logic                 clk,
	input  logic                 load,
	input  blend_req_t           req,
	input  logic [ENTRY_W-1:0]   win [9],
	output pixel_t               pix
);
	logic [2:0]         col_ok;
	logic [2:0]         row_ok;
	logic [SUM_W-1:0]   sr, sg, sb;
	logic [CNT_W-1:0]   cnt;
	logic [ENTRY_W-1:0] center;

	logic [SUM_W-1:0]   sr_q, sg_q, sb_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ENTRY_W-1:0] center_q;

	logic [RECIP_W-1:0]         rc;
	logic [SUM_W+RECIP_W-1:0]   pr, pg, pb;

	always_comb begin
		col_ok[0] = !req.cc_right && req.left_ok;
		col_ok[1] = req.cc_right ? req.left_ok : 1'b1;
		col_ok[2] = req.cc_right ? 1'b1 : req.right_ok;
		row_ok    = {req.down_ok, 1'b1, req.up_ok};
		center    = req.cc_right ? win[7] : win[4];
		sr = '0;
		sg = '0;
		sb = '0;
		cnt = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (col_ok[c] && row_ok[r] && win[c*3+r][RGB_W]
					&& !(r == 1 && (c == 2) == req.cc_right && c != 0)) begin
					cnt = cnt + CNT_W'(1);
					sr  = sr + SUM_W'(win[c*3+r][23:16]);
					sg  = sg + SUM_W'(win[c*3+r][15:8]);
					sb  = sb + SUM_W'(win[c*3+r][7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sr_q     <= sr;
			sg_q     <= sg;
			sb_q     <= sb;
			cnt_q    <= cnt;
			center_q <= center;
		end
	end

	// a zero count gives a zero reciprocal, hence black
	assign rc = recip(cnt_q);
	assign pr = SUM_W'(sr_q) * rc;
	assign pg = SUM_W'(sg_q) * rc;
	assign pb = SUM_W'(sb_q) * rc;

	always_comb begin
		if (center_q[RGB_W]) begin
			pix.red   = center_q[23:16];
			pix.green = center_q[15:8];
			pix.blue  = center_q[7:0];
			pix.alpha = OPAQUE_ALPHA;
		end else begin
			pix.red   = pr[23:16];
			pix.green = pg[23:16];
			pix.blue  = pb[23:16];
			pix.alpha = '0;
		end
	end
endmodule

### design/transparent_pixel_color_bleed_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transparent_pixel_color_bleed_top
// Palette expander; transparent pixels take the average of opaque neighbors.
// ----------------------------------------------------------------------------
// One item at a time: a palette write completes while idle; a pixel passes the
// row store read, then for each emitted result (up to 2) the neighbor sum stage
// and the divide stage, which can stall until the output register is free.
// Results lag one row; a row of drain items flushes the last row.
// Reset clears counters, window and output valid flag; palette and row stores
// hold no reset value and need none. Register writes restart the frame.
module transparent_pixel_color_bleed_top import tpcb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	tpcb_in_if.sink             pix_in,
	tpcb_out_if.source          pix_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);
	state_t state_q, state_d;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [ENTRY_W-1:0]  win_q [9];
	logic                idx_nz_q;
	logic                e2_q, left1_q, left2_q, up_q, down_q, last_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                drain, at_end, cfg_we, accept, item_live;
	logic                row_we, out_load, blend_load;
	logic [RGB_W-1:0]    pal_rd;
	logic [ENTRY_W-1:0]  older_rd, newer_rd, cur;
	blend_req_t          req;
	pixel_t              pix;

	logic       out_valid_q;
	pixel_t     out_pix_q;
	logic       out_last_q;

	assign w_eff  = (width_q == '0) ? WIDTH_W'(1) :
		((width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q);
	assign h_eff  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign drain  = row_q >= h_eff;
	assign at_end = {1'b0, col_q} == (w_eff - WIDTH_W'(1));

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign pix_in.ready = (state_q == ST_IDLE);
	assign accept       = pix_in.valid && pix_in.ready;
	assign item_live    = accept && ((pix_in.mode == MODE_PIXEL && !drain)
		|| (pix_in.mode == MODE_DRAIN && drain));

	tpcb_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_SIZE)) u_palette (
		.clk   (clk),
		.en    (accept),
		.we    (pix_in.mode == MODE_PALETTE),
		.addr  (pix_in.mode == MODE_PALETTE ? pix_in.palette_slot : pix_in.pixel_index),
		.wdata ({pix_in.entry_red, pix_in.entry_green, pix_in.entry_blue}),
		.rdata (pal_rd)
	);

	assign row_we = (state_q == ST_LOOK) && !drain;
	assign cur    = (idx_nz_q && !drain) ? {1'b1, pal_rd} : '0;

	tpcb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.en    (item_live || row_we),
		.we    (row_we),
		.addr  (col_q),
		.wdata (newer_rd),
		.rdata (older_rd)
	);

	tpcb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk   (clk),
		.en    (item_live || row_we),
		.we    (row_we),
		.addr  (col_q),
		.wdata (cur),
		.rdata (newer_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= WIDTH_W'(64);
			height_q <= HEIGHT_W'(64);
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (paddr[2] == REG_WIDTH) begin
					width_q <= pwdata[WIDTH_W-1:0];
				end else begin
					height_q <= pwdata[HEIGHT_W-1:0];
				end
				col_q <= '0;
				row_q <= '0;
				for (int i = 0; i < 9; i++) win_q[i] <= '0;
			end else if (state_q == ST_LOOK) begin
				for (int i = 0; i < 6; i++) win_q[i] <= win_q[i+3];
				win_q[6] <= older_rd;
				win_q[7] <= newer_rd;
				win_q[8] <= cur;
				if (at_end) begin
					col_q <= '0;
					row_q <= drain ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_nz_q <= (pix_in.pixel_index != '0);
		end
		if (state_q == ST_LOOK) begin
			e2_q    <= (row_q != '0) && at_end;
			left1_q <= col_q >= COL_W'(2);
			left2_q <= col_q != '0;
			up_q    <= row_q >= HEIGHT_W'(2);
			down_q  <= !drain;
			last_q  <= drain;
		end
	end

	always_comb begin
		state_d    = state_q;
		blend_load = 1'b0;
		out_load   = 1'b0;
		req        = '{cc_right: 1'b0, left_ok: left1_q, right_ok: 1'b1,
			up_ok: up_q, down_ok: down_q};
		unique case (state_q)
			ST_IDLE: begin
				if (item_live) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if ((row_q != '0) && (col_q != '0)) state_d = ST_SUM1;
				else if ((row_q != '0) && at_end) state_d = ST_SUM2;
				else state_d = ST_IDLE;
			end
			ST_SUM1: begin
				blend_load = 1'b1;
				state_d    = ST_OUT1;
			end
			ST_OUT1: begin
				if (!out_valid_q || pix_out.ready) begin
					out_load = 1'b1;
					state_d  = e2_q ? ST_SUM2 : ST_IDLE;
				end
			end
			ST_SUM2: begin
				req = '{cc_right: 1'b1, left_ok: left2_q, right_ok: 1'b0,
					up_ok: up_q, down_ok: down_q};
				blend_load = 1'b1;
				state_d    = ST_OUT2;
			end
			ST_OUT2: begin
				if (!out_valid_q || pix_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	tpcb_blend u_blend (
		.clk  (clk),
		.load (blend_load),
		.req  (req),
		.win  (win_q),
		.pix  (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= pix;
			out_last_q <= (state_q == ST_OUT2) && last_q;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.out_red    = out_pix_q.red;
	assign pix_out.out_green  = out_pix_q.green;
	assign pix_out.out_blue   = out_pix_q.blue;
	assign pix_out.out_alpha  = out_pix_q.alpha;
	assign pix_out.frame_last = out_last_q;

	a_live_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		item_live |=> state_q == ST_LOOK)
		else $error("live item did not start a lookup");
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < w_eff || cfg_we || $past(cfg_we))
		else $error("column counter beyond width");
	a_row_we_look: assert property (@(posedge clk) disable iff (!arst_n)
		row_we |-> !pix_in.ready)
		else $error("row store written while accepting");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pix_out.ready))
		else $error("output register overwritten");
endmodule
